@@ design/e2i_pkg.sv @@
// Shared types, constants and arithmetic helpers for the epoch-to-ISO-8601 text block.
package e2i_pkg;

    localparam int NSTAGE  = 27;   // arithmetic pipeline depth
    localparam int DSTAGES = 8;    // digit stages at the tail of the pipeline
    localparam int TS_LEN  = 30;   // characters per timestamp

    // ns + 2^63 + NS_BIAS is an exact multiple of 1e9 at the epoch
    localparam logic [64:0] NS_BIAS     = 65'd145224192;
    localparam logic [29:0] NS_PER_SEC  = 30'd1000000000;
    // seconds offset so that the biased seconds are a multiple of 86400 at the epoch
    localparam logic [34:0] SEC_BIAS    = 35'd763;
    localparam logic [16:0] SEC_PER_DAY = 17'd86400;
    // biased day number plus DAY_BIAS is the civil-from-days z value
    localparam logic [19:0] DAY_BIAS    = 20'd612716;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_Z     = 8'h5A;

    typedef logic [7:0] char_t;
    typedef char_t [TS_LEN-1:0] text_t;

    typedef struct packed {
        logic [9:0]  q;
        logic [29:0] r;
    } qr_t;

    // partial long division by 1e9
    typedef struct packed {
        logic [29:0] rem;
        logic [34:0] quo;
        logic [34:0] low;
    } d1_t;

    // partial long division by 86400
    typedef struct packed {
        logic [16:0] rem;
        logic [17:0] quo;
        logic [17:0] low;
    } d2_t;

    // restoring division, quotient bits hi..lo only
    function automatic qr_t cdiv(input logic [29:0] val, input logic [29:0] dv,
                                 input int hi, input int lo);
        qr_t         res;
        logic [39:0] r;
        logic [39:0] m;
        res.q = '0;
        r = {10'd0, val};
        for (int i = 9; i >= 0; i--) begin
            m = {10'd0, dv} << i;
            if (i <= hi && i >= lo && r >= m) begin
                r = r - m;
                res.q[i] = 1'b1;
            end
        end
        res.r = r[29:0];
        return res;
    endfunction

    // five quotient bits of the division by 1e9
    function automatic d1_t div1e9_step(input d1_t s);
        d1_t         o;
        logic [30:0] t;
        o = s;
        for (int i = 0; i < 5; i++) begin
            t = {o.rem, o.low[34]};
            o.low = {o.low[33:0], 1'b0};
            if (t >= {1'b0, NS_PER_SEC}) begin
                t = t - {1'b0, NS_PER_SEC};
                o.quo = {o.quo[33:0], 1'b1};
            end else begin
                o.quo = {o.quo[33:0], 1'b0};
            end
            o.rem = t[29:0];
        end
        return o;
    endfunction

    // six quotient bits of the division by 86400
    function automatic d2_t div86k_step(input d2_t s);
        d2_t         o;
        logic [17:0] t;
        o = s;
        for (int i = 0; i < 6; i++) begin
            t = {o.rem, o.low[17]};
            o.low = {o.low[16:0], 1'b0};
            if (t >= {1'b0, SEC_PER_DAY}) begin
                t = t - {1'b0, SEC_PER_DAY};
                o.quo = {o.quo[16:0], 1'b1};
            end else begin
                o.quo = {o.quo[16:0], 1'b0};
            end
            o.rem = t[16:0];
        end
        return o;
    endfunction

    function automatic logic [29:0] pow10(input int n);
        logic [29:0] r;
        r = 30'd1;
        for (int i = 0; i < 9; i++) begin
            if (i < n) begin
                r = 30'(r * 30'd10);
            end
        end
        return r;
    endfunction

    // day of the March-based year on which month index mp starts
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic char_t digit_char(input logic [3:0] d);
        return CH_ZERO + {4'd0, d};
    endfunction

    function automatic text_t make_template();
        text_t t;
        for (int i = 0; i < TS_LEN; i++) begin
            t[i] = CH_ZERO;
        end
        t[4]  = CH_DASH;
        t[7]  = CH_DASH;
        t[10] = CH_T;
        t[13] = CH_COLON;
        t[16] = CH_COLON;
        t[19] = CH_DOT;
        t[29] = CH_Z;
        return t;
    endfunction

    localparam text_t TEXT_TEMPLATE = make_template();

endpackage

@@ design/e2i_calc.sv @@
// Arithmetic pipeline: epoch nanoseconds to the full 30-character timestamp text.
module e2i_calc (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [63:0]  epoch_nanos,
    output logic                out_valid,
    input  logic                out_ready,
    output e2i_pkg::text_t      text
);
    import e2i_pkg::*;

    logic              advance;
    logic [NSTAGE-1:0] v_reg;

    // stage 0
    logic [64:0] u_reg;
    // stages 1..7
    d1_t         da_reg [0:6];
    d1_t         da_init;
    // stage 8
    logic [34:0] s2_reg;
    logic [29:0] fr8_reg;
    // stages 9..11
    d2_t         db_reg [0:2];
    d2_t         db_init;
    logic [29:0] frb_reg [0:2];
    // stage 12
    logic [2:0]  era12_reg;
    logic [17:0] doe12_reg;
    logic [4:0]  hh12_reg;
    logic [11:0] rs12_reg;
    logic [29:0] fr12_reg;
    // stage 13
    logic [2:0]  era13_reg;
    logic [17:0] doe13_reg;
    logic [6:0]  n1_13_reg;
    logic [2:0]  n2_13_reg;
    logic        n3_13_reg;
    logic [4:0]  hh13_reg;
    logic [5:0]  mm13_reg;
    logic [5:0]  ss13_reg;
    logic [29:0] fr13_reg;
    // stage 14
    logic [2:0]  era14_reg;
    logic [17:0] doe14_reg;
    logic [8:0]  yh14_reg;
    logic [12:0] yrem14_reg;
    text_t       tx14_reg;
    logic [29:0] fr14_reg;
    // stage 15
    logic [2:0]  era15_reg;
    logic [17:0] doe15_reg;
    logic [8:0]  yoe15_reg;
    text_t       tx15_reg;
    logic [29:0] fr15_reg;
    // stage 16
    logic [8:0]  doy16_reg;
    logic [11:0] ypart16_reg;
    text_t       tx16_reg;
    logic [29:0] fr16_reg;
    // stage 17
    logic [8:0]  doy17_reg;
    logic [11:0] ypart17_reg;
    logic [3:0]  mp17_reg;
    text_t       tx17_reg;
    logic [29:0] fr17_reg;
    // stage 18
    logic [11:0] yr18_reg;
    logic [3:0]  mo18_reg;
    logic [4:0]  dd18_reg;
    text_t       tx18_reg;
    logic [29:0] fr18_reg;
    // digit stages 19..26
    text_t       tx_d_reg [0:DSTAGES-1];
    logic [29:0] fr_d_reg [0:DSTAGES-1];
    logic [11:0] yr_d_reg [0:DSTAGES-1];
    text_t       tx_in [0:DSTAGES-1];
    logic [29:0] fr_in [0:DSTAGES-1];
    logic [11:0] yr_in [0:DSTAGES-1];

    // combinational helpers
    logic [19:0] z12;
    qr_t         qe12, qh12, qn1, qn2, qm13, qy14, qh14a, qm14a, qs14a, ql15, qmp17;
    logic [17:0] t14;
    text_t       tx14_next;
    logic [1:0]  c100;
    logic [17:0] yoe_x365;
    logic [10:0] v17;
    logic [3:0]  mo_next;

    // the whole pipe moves together unless the last stage is held
    assign advance   = !v_reg[NSTAGE-1] || out_ready;
    assign in_stall  = !advance;
    assign out_valid = v_reg[NSTAGE-1];
    assign text      = tx_d_reg[DSTAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[NSTAGE-2:0], in_valid};
        end
    end

    always_comb
    begin
        da_init = '{rem: u_reg[64:35], quo: '0, low: u_reg[34:0]};
        db_init = '{rem: s2_reg[34:18], quo: '0, low: s2_reg[17:0]};

        z12  = {2'd0, db_reg[2].quo} + DAY_BIAS;
        qe12 = cdiv({10'd0, z12}, 30'd146097, 2, 0);
        qh12 = cdiv({13'd0, db_reg[2].rem}, 30'd3600, 4, 0);

        qn1  = cdiv({12'd0, doe12_reg}, 30'd1460, 6, 0);
        qn2  = cdiv({12'd0, doe12_reg}, 30'd36524, 2, 0);
        qm13 = cdiv({18'd0, rs12_reg}, 30'd60, 5, 0);

        t14   = doe13_reg - {11'd0, n1_13_reg} + {15'd0, n2_13_reg} - {17'd0, n3_13_reg};
        qy14  = cdiv({12'd0, t14}, 30'd365, 8, 4);
        qh14a = cdiv({25'd0, hh13_reg}, 30'd10, 3, 0);
        qm14a = cdiv({24'd0, mm13_reg}, 30'd10, 3, 0);
        qs14a = cdiv({24'd0, ss13_reg}, 30'd10, 3, 0);
        tx14_next     = TEXT_TEMPLATE;
        tx14_next[11] = digit_char(qh14a.q[3:0]);
        tx14_next[12] = digit_char(qh14a.r[3:0]);
        tx14_next[14] = digit_char(qm14a.q[3:0]);
        tx14_next[15] = digit_char(qm14a.r[3:0]);
        tx14_next[17] = digit_char(qs14a.q[3:0]);
        tx14_next[18] = digit_char(qs14a.r[3:0]);

        ql15 = cdiv({17'd0, yrem14_reg}, 30'd365, 3, 0);

        c100 = (yoe15_reg >= 9'd300) ? 2'd3 :
               (yoe15_reg >= 9'd200) ? 2'd2 :
               (yoe15_reg >= 9'd100) ? 2'd1 : 2'd0;
        yoe_x365 = {9'd0, yoe15_reg} * 18'd365;

        v17   = {doy16_reg, 2'b00} + {2'd0, doy16_reg} + 11'd2;
        qmp17 = cdiv({19'd0, v17}, 30'd153, 3, 0);

        mo_next = (mp17_reg < 4'd10) ? mp17_reg + 4'd3 : mp17_reg - 4'd9;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // stage 0: bias to an unsigned dividend
            u_reg <= {1'b0, ~epoch_nanos[63], epoch_nanos[62:0]} + NS_BIAS;

            // stages 1..7: seconds and nanosecond remainder
            da_reg[0] <= div1e9_step(da_init);
            for (int k = 1; k < 7; k++) begin
                da_reg[k] <= div1e9_step(da_reg[k-1]);
            end

            // stage 8
            s2_reg  <= da_reg[6].quo + SEC_BIAS;
            fr8_reg <= da_reg[6].rem;

            // stages 9..11: days and second of day
            db_reg[0]  <= div86k_step(db_init);
            frb_reg[0] <= fr8_reg;
            for (int k = 1; k < 3; k++) begin
                db_reg[k]  <= div86k_step(db_reg[k-1]);
                frb_reg[k] <= frb_reg[k-1];
            end

            // stage 12: era, day of era, hours
            era12_reg <= qe12.q[2:0];
            doe12_reg <= qe12.r[17:0];
            hh12_reg  <= qh12.q[4:0];
            rs12_reg  <= qh12.r[11:0];
            fr12_reg  <= frb_reg[2];

            // stage 13: leap corrections, minutes, seconds
            era13_reg <= era12_reg;
            doe13_reg <= doe12_reg;
            n1_13_reg <= qn1.q[6:0];
            n2_13_reg <= qn2.q[2:0];
            n3_13_reg <= (doe12_reg >= 18'd146096);
            hh13_reg  <= hh12_reg;
            mm13_reg  <= qm13.q[5:0];
            ss13_reg  <= qm13.r[5:0];
            fr13_reg  <= fr12_reg;

            // stage 14: high bits of year of era, time characters
            era14_reg  <= era13_reg;
            doe14_reg  <= doe13_reg;
            yh14_reg   <= qy14.q[8:0];
            yrem14_reg <= qy14.r[12:0];
            tx14_reg   <= tx14_next;
            fr14_reg   <= fr13_reg;

            // stage 15: low bits of year of era
            era15_reg <= era14_reg;
            doe15_reg <= doe14_reg;
            yoe15_reg <= yh14_reg | ql15.q[8:0];
            tx15_reg  <= tx14_reg;
            fr15_reg  <= fr14_reg;

            // stage 16: day of year, year before the March shift
            doy16_reg   <= 9'(doe15_reg - (yoe_x365 + {11'd0, yoe15_reg[8:2]}
                                           - {16'd0, c100}));
            ypart16_reg <= ({9'd0, era15_reg} * 12'd400) + {3'd0, yoe15_reg};
            tx16_reg    <= tx15_reg;
            fr16_reg    <= fr15_reg;

            // stage 17: month index
            doy17_reg   <= doy16_reg;
            ypart17_reg <= ypart16_reg;
            mp17_reg    <= qmp17.q[3:0];
            tx17_reg    <= tx16_reg;
            fr17_reg    <= fr16_reg;

            // stage 18: civil year, month, day
            dd18_reg <= 5'(doy17_reg - month_start(mp17_reg) + 9'd1);
            mo18_reg <= mo_next;
            yr18_reg <= ypart17_reg + {11'd0, (mo_next <= 4'd2)};
            tx18_reg <= tx17_reg;
            fr18_reg <= fr17_reg;
        end
    end

    // stages 19..26: a fraction digit each (two in 26); year in 19..21, date in 19
    for (genvar k = 0; k < DSTAGES; k++) begin : g_dig
        text_t       tx_next;
        logic [29:0] fr_next;
        logic [11:0] yr_next;
        qr_t         qf, qy, qa, qb;

        if (k == 0) begin : g_first
            assign tx_in[k] = tx18_reg;
            assign fr_in[k] = fr18_reg;
            assign yr_in[k] = yr18_reg;
        end else begin : g_rest
            assign tx_in[k] = tx_d_reg[k-1];
            assign fr_in[k] = fr_d_reg[k-1];
            assign yr_in[k] = yr_d_reg[k-1];
        end

        always_comb
        begin
            tx_next = tx_in[k];
            qf = cdiv(fr_in[k], pow10(8 - k), 3, 0);
            tx_next[20+k] = digit_char(qf.q[3:0]);
            fr_next = qf.r;
            if (k == DSTAGES - 1)
            begin
                tx_next[28] = digit_char(qf.r[3:0]);
            end
            qy = cdiv({18'd0, yr_in[k]}, pow10(3 - k), 3, 0);
            yr_next = yr_in[k];
            if (k < 3)
            begin
                tx_next[k] = digit_char(qy.q[3:0]);
                yr_next    = qy.r[11:0];
                if (k == 2)
                begin
                    tx_next[3] = digit_char(qy.r[3:0]);
                end
            end
            qa = cdiv({26'd0, mo18_reg}, 30'd10, 3, 0);
            qb = cdiv({25'd0, dd18_reg}, 30'd10, 3, 0);
            if (k == 0)
            begin
                tx_next[5] = digit_char(qa.q[3:0]);
                tx_next[6] = digit_char(qa.r[3:0]);
                tx_next[8] = digit_char(qb.q[3:0]);
                tx_next[9] = digit_char(qb.r[3:0]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                tx_d_reg[k] <= tx_next;
                fr_d_reg[k] <= fr_next;
                yr_d_reg[k] <= yr_next;
            end
        end
    end

endmodule

@@ design/epoch_ns_to_iso8601_text_top.sv @@
// Top level: epoch nanoseconds in, ISO-8601 UTC timestamp text out one character per item.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  in      | input     | in_valid / in_stall    | epoch_nanos (s64)
//  out     | output    | out_valid / out_stall  | text_char (u8), is_last
//
// Each input item yields 30 output items, YYYY-MM-DDTHH:MM:SS.nnnnnnnnnZ, with
// is_last set on the closing 'Z'. The arithmetic runs in a 27-stage pipeline
// (long division by 1e9 over 7 stages, by 86400 over 3, civil date over 7,
// digit extraction over 8). The one-character output port sets the sustained
// rate, as the serializer takes a new timestamp only when empty or as the final
// 'Z' leaves. The pipeline moves as one and holds whenever its last stage holds
// a finished item the serializer cannot yet take.
// Reset (rst_n low, asynchronous) clears the valid bits and the serializer;
// no data registers are cleared. Stalls never drop or repeat a character.
module epoch_ns_to_iso8601_text_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [63:0] epoch_nanos,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         text_char,
    output logic               is_last
);
    import e2i_pkg::*;

    logic        calc_valid;
    logic        calc_ready;
    text_t       calc_text;

    // serializer: holds one full timestamp and shifts it out
    text_t       sh_reg;
    text_t       sh_next;
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic        ov_reg;
    logic        ov_next;
    logic        at_end;
    logic        load;
    logic        take;

    e2i_calc u_calc (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .epoch_nanos(epoch_nanos),
        .out_valid  (calc_valid),
        .out_ready  (calc_ready),
        .text       (calc_text)
    );

    assign at_end     = (cnt_reg == 5'(TS_LEN - 1));
    assign take       = ov_reg && !out_stall;
    // a new timestamp comes in when empty or as the final 'Z' leaves
    assign calc_ready = !ov_reg || (!out_stall && at_end);
    assign load       = calc_valid && calc_ready;

    always_comb
    begin
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        ov_next  = ov_reg;
        if (load)
        begin
            sh_next  = calc_text;
            cnt_next = '0;
            ov_next  = 1'b1;
        end
        else if (take)
        begin
            if (at_end)
            begin
                ov_next = 1'b0;
            end
            else
            begin
                sh_next  = sh_reg >> 8;
                cnt_next = cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

    assign out_valid = ov_reg;
    assign text_char = sh_reg[0];
    assign is_last   = ov_reg && at_end;

endmodule

@@ design/e2i_check.sv @@
// Port-level checker for the timestamp text block, with its bind.
module e2i_check (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic signed [63:0] epoch_nanos,
    input logic               out_valid,
    input logic               out_stall,
    input logic [7:0]         text_char,
    input logic               is_last
);
    import e2i_pkg::*;

    // more characters follow until the terminator
    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !is_last |=> out_valid)
        else $error("timestamp cut short");

    // the terminator is always 'Z'
    a_zend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_last |-> text_char == CH_Z)
        else $error("last item is not Z");

    // two terminators never come back to back
    a_noreplast: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_last && !out_stall |=> !(out_valid && is_last))
        else $error("terminator repeated");

    // stalled output holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(text_char) && $stable(is_last))
        else $error("stalled output changed");

    // a stalled input item stays offered and unchanged
    a_inhold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(epoch_nanos))
        else $error("stalled input changed");

endmodule

bind epoch_ns_to_iso8601_text_top e2i_check u_e2i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .epoch_nanos(epoch_nanos),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .text_char  (text_char),
    .is_last    (is_last)
);
